// ----- src/fpd_pkg.sv -----
`default_nettype none

package fpd_pkg;

  localparam int VALUE_W       = 64;
  localparam int CODE_W        = 3;
  localparam int RES_BYTES_W   = 4;
  localparam int FCM_SHIFT     = 6;
  localparam int STRIDE_SHIFT  = 2;
  localparam int FCM_HASH_LSB  = 48;
  localparam int STRIDE_HASH_LSB = 40;

  localparam logic [CODE_W-1:0] BC_0B = 3'd0;
  localparam logic [CODE_W-1:0] BC_1B = 3'd1;
  localparam logic [CODE_W-1:0] BC_2B = 3'd2;
  localparam logic [CODE_W-1:0] BC_3B = 3'd3;
  localparam logic [CODE_W-1:0] BC_5B = 3'd4;
  localparam logic [CODE_W-1:0] BC_6B = 3'd5;
  localparam logic [CODE_W-1:0] BC_7B = 3'd6;
  localparam logic [CODE_W-1:0] BC_8B = 3'd7;

  typedef struct packed {
    logic                   use_stride_predictor;
    logic [CODE_W-1:0]      byte_code;
    logic [VALUE_W-1:0]     residual;
    logic [RES_BYTES_W-1:0] residual_bytes;
  } res_t;

  // leading zero byte class, no 4-byte class
  function automatic logic [CODE_W-1:0] leading_code(input logic [VALUE_W-1:0] r);
    logic [CODE_W-1:0] c;
    c = BC_8B;
    if (r[63:56] == '0) c = BC_7B;
    if (r[63:48] == '0) c = BC_6B;
    if (r[63:40] == '0) c = BC_5B;
    if (r[63:24] == '0) c = BC_3B;
    if (r[63:16] == '0) c = BC_2B;
    if (r[63:8] == '0) c = BC_1B;
    if (r == '0) c = BC_0B;
    return c;
  endfunction

  function automatic logic [RES_BYTES_W-1:0] code_bytes(input logic [CODE_W-1:0] c);
    return {1'b0, c} + {3'b000, c[2]};
  endfunction

endpackage

`default_nettype wire

// ----- src/fpd_if.sv -----
`default_nettype none

interface fpd_in_if import fpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value_bits;

  modport source (output valid, output value_bits, input ready);
  modport sink (input valid, input value_bits, output ready);
endinterface

interface fpd_out_if import fpd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   use_stride_predictor;
  logic [CODE_W-1:0]      byte_code;
  logic [VALUE_W-1:0]     residual;
  logic [RES_BYTES_W-1:0] residual_bytes;

  modport source (output valid, output use_stride_predictor, output byte_code,
                  output residual, output residual_bytes, input ready);
  modport sink (input valid, input use_stride_predictor, input byte_code,
                input residual, input residual_bytes, output ready);
endinterface

`default_nettype wire

// ----- src/fcm_dfcm_double_predictor_top.sv -----
// fcm/dfcm double predictor
// in_ch (valid/ready) carries one 64-bit double bit pattern per item; out_ch
// (valid/ready) returns one result per item: predictor select, byte code,
// residual and residual byte count. an item is taken when valid and ready
// are both high.
// after reset both 2^TABLE_BITS x 64 tables are cleared one entry per cycle,
// with in_ch.ready held low; the index, history and guess registers reset to
// zero. an item cannot be taken while the registered table read for the
// previous item is pending, since the next index and guess come from the
// current item. its residuals are registered when it is taken and then
// pushed into a two-entry result buffer that drives out_ch and decouples the
// sides; when the receiver stalls the buffer fills and in_ch.ready drops
// until a result is taken on out_ch.
`default_nettype none

module fcm_dfcm_double_predictor_top import fpd_pkg::*; #(
  parameter int TABLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  fpd_in_if.sink     in_ch,
  fpd_out_if.source  out_ch
);

  logic                  clearing_r;
  logic [TABLE_BITS-1:0] clr_addr_r;
  logic                  busy_r;
  logic [TABLE_BITS-1:0] fcm_idx_r;
  logic [TABLE_BITS-1:0] stride_idx_r;
  logic [TABLE_BITS-1:0] fcm_idx_nxt;
  logic [TABLE_BITS-1:0] stride_idx_nxt;
  logic [VALUE_W-1:0]    prev_r;
  logic [VALUE_W-1:0]    fcm_guess_r;
  logic [VALUE_W-1:0]    pred2_r;
  logic [VALUE_W-1:0]    r1_r;
  logic [VALUE_W-1:0]    r2_r;
  logic [VALUE_W-1:0]    stride_wval_r;
  logic                  fcm_fwd_r;
  logic                  stride_fwd_r;

  logic                  accept;
  logic                  room;
  logic [VALUE_W-1:0]    v;
  logic [VALUE_W-1:0]    s;
  logic [VALUE_W-1:0]    fcm_hash;
  logic [VALUE_W-1:0]    stride_hash;
  logic                  tbl_we;
  logic [TABLE_BITS-1:0] fcm_waddr;
  logic [TABLE_BITS-1:0] stride_waddr;
  logic [VALUE_W-1:0]    fcm_wdata;
  logic [VALUE_W-1:0]    stride_wdata;
  logic [VALUE_W-1:0]    fcm_rdata;
  logic [VALUE_W-1:0]    stride_rdata;
  logic [VALUE_W-1:0]    stride_guess;
  logic                  sel;
  logic [VALUE_W-1:0]    res;
  logic [CODE_W-1:0]     code;
  res_t                  item;

  assign in_ch.ready = !clearing_r && !busy_r && room;
  assign accept      = in_ch.valid && in_ch.ready;
  assign v           = in_ch.value_bits;
  assign s           = v - prev_r;

  assign fcm_hash    = ({{(VALUE_W-TABLE_BITS){1'b0}}, fcm_idx_r} << FCM_SHIFT)
                       ^ (v >> FCM_HASH_LSB);
  assign stride_hash = ({{(VALUE_W-TABLE_BITS){1'b0}}, stride_idx_r} << STRIDE_SHIFT)
                       ^ (s >> STRIDE_HASH_LSB);
  assign fcm_idx_nxt    = fcm_hash[TABLE_BITS-1:0];
  assign stride_idx_nxt = stride_hash[TABLE_BITS-1:0];

  assign tbl_we       = clearing_r || accept;
  assign fcm_waddr    = clearing_r ? clr_addr_r : fcm_idx_r;
  assign stride_waddr = clearing_r ? clr_addr_r : stride_idx_r;
  assign fcm_wdata    = clearing_r ? '0 : v;
  assign stride_wdata = clearing_r ? '0 : s;

  fpd_ram #(.ADDR_BITS(TABLE_BITS)) u_fcm_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (fcm_waddr),
    .wdata (fcm_wdata),
    .re    (accept),
    .raddr (fcm_idx_nxt),
    .rdata (fcm_rdata)
  );

  fpd_ram #(.ADDR_BITS(TABLE_BITS)) u_stride_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (stride_waddr),
    .wdata (stride_wdata),
    .re    (accept),
    .raddr (stride_idx_nxt),
    .rdata (stride_rdata)
  );

  // forward the entry written by this item when the new index hits it
  assign stride_guess = stride_fwd_r ? stride_wval_r : stride_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r   <= 1'b1;
      clr_addr_r   <= '0;
      busy_r       <= 1'b0;
      fcm_idx_r    <= '0;
      stride_idx_r <= '0;
      prev_r       <= '0;
      fcm_guess_r  <= '0;
      pred2_r      <= '0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          clearing_r <= 1'b0;
        end
      end
      busy_r <= accept;
      if (accept) begin
        fcm_idx_r    <= fcm_idx_nxt;
        stride_idx_r <= stride_idx_nxt;
        prev_r       <= v;
      end
      if (busy_r) begin
        fcm_guess_r <= fcm_fwd_r ? prev_r : fcm_rdata;
        pred2_r     <= prev_r + stride_guess;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r1_r          <= v ^ fcm_guess_r;
      r2_r          <= v ^ pred2_r;
      stride_wval_r <= s;
      fcm_fwd_r     <= (fcm_idx_nxt == fcm_idx_r);
      stride_fwd_r  <= (stride_idx_nxt == stride_idx_r);
    end
  end

  assign sel  = (r1_r > r2_r);
  assign res  = sel ? r2_r : r1_r;
  assign code = leading_code(res);

  always_comb begin
    item.use_stride_predictor = sel;
    item.byte_code            = code;
    item.residual             = res;
    item.residual_bytes       = code_bytes(code);
  end

  fpd_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (busy_r),
    .push_item (item),
    .room      (room),
    .out_ch    (out_ch)
  );

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !clearing_r)
    else $error("item taken during table clear");

  a_one_per_two: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && !in_ch.ready)
    else $error("item taken while table read pending");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r && clr_addr_r == '1 |=> !clearing_r)
    else $error("table clear did not finish");

endmodule

`default_nettype wire

// ----- src/fpd_ram.sv -----
`default_nettype none

module fpd_ram import fpd_pkg::*; #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [VALUE_W-1:0]   wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [VALUE_W-1:0]   rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read before write on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- src/fpd_res_fifo.sv -----
`default_nettype none

module fpd_res_fifo import fpd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  res_t         push_item,
  output logic         room,
  fpd_out_if.source    out_ch
);

  localparam logic [1:0] FULL = 2'd2;

  res_t       buf_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       pop;
  res_t       head;

  assign pop  = out_ch.valid && out_ch.ready;
  assign room = (count_r != FULL);
  assign head = buf_r[rd_ptr_r];

  assign out_ch.valid                = (count_r != 2'd0);
  assign out_ch.use_stride_predictor = head.use_stride_predictor;
  assign out_ch.byte_code            = head.byte_code;
  assign out_ch.residual             = head.residual;
  assign out_ch.residual_bytes       = head.residual_bytes;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != FULL || pop))
    else $error("result buffer overflow");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> count_r == $past(count_r) - 2'd1)
    else $error("result buffer count mismatch on pop");

endmodule

`default_nettype wire
